// ----- design/key_matrix_to_hid_report_defines.svh -----
// assertion macros shared by the keyboard report design
`ifndef KEY_MATRIX_TO_HID_REPORT_DEFINES_SVH
`define KEY_MATRIX_TO_HID_REPORT_DEFINES_SVH

// same-cycle check: when ante holds, cons must hold in that cycle
`define KMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check: when ante holds, cons must hold in the next cycle
`define KMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kmh_pkg.sv -----
// shared types and constants of the keyboard matrix to hid report block
package kmh_pkg;

  // default geometry
  localparam int ROWS_DEF        = 16;
  localparam int COLUMNS_DEF     = 8;
  localparam int REPORT_KEYS_DEF = 6;

  // number of key slot ports in a boot report
  localparam int SLOT_COUNT = 6;

  // keycode classes
  localparam logic [7:0] FN_CODE    = 8'hFF;
  localparam logic [7:0] KEY_LIMIT  = 8'hF0;
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_LOAD_NORMAL   = 3'd0,
    OP_LOAD_FN       = 3'd1,
    OP_SAMPLE_FIRST  = 3'd2,
    OP_SAMPLE_SECOND = 3'd3,
    OP_REPORT        = 3'd4
  } kmh_op_t;

  // report sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FN_PASS,
    S_KEY_PASS,
    S_FLUSH,
    S_EMIT
  } kmh_state_t;

  // keymap write strobes
  typedef struct packed {
    logic normal;
    logic fn;
  } kmh_wr_t;

endpackage

// ----- design/kmh_keymap.sv -----
// normal and function layer keymap memories with registered read
module kmh_keymap #(
  parameter int DEPTH = kmh_pkg::ROWS_DEF * kmh_pkg::COLUMNS_DEF,
  parameter int AW    = 7
) (
  input  logic            clk,
  input  kmh_pkg::kmh_wr_t wr,
  input  logic [AW-1:0]   wr_addr,
  input  logic [7:0]      wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [7:0]      normal_q,
  output logic [7:0]      fn_q
);
  import kmh_pkg::*;

  logic [7:0] normal_mem [DEPTH];
  logic [7:0] fn_mem [DEPTH];

  // normal layer
  always_ff @(posedge clk) begin
    if (wr.normal) begin
      normal_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      normal_q <= normal_mem[rd_addr];
    end
  end

  // function layer
  always_ff @(posedge clk) begin
    if (wr.fn) begin
      fn_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      fn_q <= fn_mem[rd_addr];
    end
  end

endmodule

// ----- design/key_matrix_to_hid_report.sv -----
// keyboard matrix scan to hid boot report, top level
//
// One input channel (in_valid/in_ready) carries command beats: keymap entry
// loads for the normal and function layers, the two debounce samples of a
// row, and report requests. One result channel (out_valid/out_ready) carries
// a boot report: six key slots, the modifier mask and the filled slot count.
// Only a report request gives a result beat.
// Loads and sample writes finish as they are accepted; in_ready stays high for them.
// A report scans the keymap memories twice over ROWS*COLUMNS addresses, one
// read a cycle: first for the function key, then for the report itself.
// out_valid rises when the report is loaded into the output register and
// in_ready returns in that same cycle, so a new report is accepted only
// after the previous one has left the sequencer.
// The scan length is set by the single read port of each keymap.
// If the receiver stalls, a report may still scan; it then waits before the
// output register until the previous beat is taken. Reset clears both sample
// tables and the sequencer; keymap contents are undefined until loaded.
module key_matrix_to_hid_report #(
  parameter int ROWS        = kmh_pkg::ROWS_DEF,
  parameter int COLUMNS     = kmh_pkg::COLUMNS_DEF,
  parameter int REPORT_KEYS = kmh_pkg::REPORT_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [3:0] in_row,
  input  logic [2:0] in_column,
  input  logic [7:0] in_map_code,
  input  logic [7:0] in_sense_bits,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_key_slot0,
  output logic [7:0] out_key_slot1,
  output logic [7:0] out_key_slot2,
  output logic [7:0] out_key_slot3,
  output logic [7:0] out_key_slot4,
  output logic [7:0] out_key_slot5,
  output logic [7:0] out_modifier_mask,
  output logic [2:0] out_keys_used
);
  import kmh_pkg::*;
  `include "key_matrix_to_hid_report_defines.svh"

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int UW    = $clog2(REPORT_KEYS + 1);
  localparam int SW    = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;

  localparam logic [AW-1:0]    ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [UW-1:0]    USED_MAX  = UW'(REPORT_KEYS);

  kmh_state_t state_r, state_nxt;

  logic [AW-1:0]    addr_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;

  logic       v_r;
  logic       key_pass_r;
  logic       down_r;
  logic       fn_r;
  logic [7:0] mods_r;
  logic [UW-1:0] used_r;
  logic [7:0] slot_r [REPORT_KEYS];

  logic [7:0] first_r [ROWS];
  logic [7:0] second_r [ROWS];

  logic       out_valid_r;
  logic [7:0] out_slot_r [SLOT_COUNT];
  logic [7:0] out_mods_r;
  logic [UW-1:0] out_used_r;

  logic in_fire, report_start, scan_issue, scan_last, emit_go;
  logic row_ok, col_ok;
  logic [AW-1:0] wr_addr;
  kmh_wr_t    map_wr;
  logic [7:0] normal_q, fn_q, code_sel, both;
  logic       code_live, code_mod;

  // command decode
  assign in_fire      = in_valid && in_ready;
  assign report_start = in_fire && (in_opcode == OP_REPORT);
  assign row_ok       = ({2'b00, in_row} < 6'(ROWS));
  assign col_ok       = ({1'b0, in_column} < 4'(COLUMNS));
  assign wr_addr      = AW'(32'(in_row) * 32'(COLUMNS) + 32'(in_column));
  assign map_wr.normal = in_fire && (in_opcode == OP_LOAD_NORMAL) && row_ok && col_ok;
  assign map_wr.fn     = in_fire && (in_opcode == OP_LOAD_FN) && row_ok && col_ok;

  kmh_keymap #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_keymap (
    .clk      (clk),
    .wr       (map_wr),
    .wr_addr  (wr_addr),
    .wr_data  (in_map_code),
    .rd_en    (scan_issue),
    .rd_addr  (addr_r),
    .normal_q (normal_q),
    .fn_q     (fn_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (report_start) state_nxt = S_FN_PASS;
      S_FN_PASS:  if (scan_last) state_nxt = S_KEY_PASS;
      S_KEY_PASS: if (scan_last) state_nxt = S_FLUSH;
      S_FLUSH:    state_nxt = S_EMIT;
      S_EMIT:     if (emit_go) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    scan_issue = (state_r == S_FN_PASS) || (state_r == S_KEY_PASS);
    scan_last  = (addr_r == ADDR_LAST);
    emit_go    = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // debounce sample tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        first_r[i]  <= '0;
        second_r[i] <= '0;
      end
    end else if (in_fire && row_ok) begin
      if (in_opcode == OP_SAMPLE_FIRST) begin
        first_r[ROW_W'(in_row)] <= in_sense_bits;
      end
      if (in_opcode == OP_SAMPLE_SECOND) begin
        second_r[ROW_W'(in_row)] <= in_sense_bits;
      end
    end
  end

  // scan address walk, row and column kept alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (report_start || (scan_issue && scan_last)) begin
      addr_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (scan_issue) begin
      addr_r <= addr_r + 1'b1;
      if (col_r == COL_LAST) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // pressed bit and pass tag travel with the memory read
  assign both = first_r[row_r] & second_r[row_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= 1'b0;
      key_pass_r <= 1'b0;
      down_r     <= 1'b0;
    end else begin
      v_r        <= scan_issue;
      key_pass_r <= (state_r == S_KEY_PASS);
      down_r     <= both[3'(col_r)];
    end
  end

  // classify the code read back
  always_comb begin
    code_sel  = fn_r ? fn_q : normal_q;
    code_live = (code_sel != 8'h00) && (code_sel < KEY_LIMIT);
    code_mod  = (code_sel[7:3] == MOD_PREFIX);
  end

  // report accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_r   <= 1'b0;
      mods_r <= '0;
      used_r <= '0;
    end else if (report_start) begin
      fn_r   <= 1'b0;
      mods_r <= '0;
      used_r <= '0;
      for (int k = 0; k < REPORT_KEYS; k++) begin
        slot_r[k] <= '0;
      end
    end else if (v_r && down_r) begin
      if (!key_pass_r) begin
        if (normal_q == FN_CODE) begin
          fn_r <= 1'b1;
        end
      end else if (code_live) begin
        if (code_mod) begin
          mods_r <= mods_r | (8'b1 << code_sel[2:0]);
        end else if (used_r < USED_MAX) begin
          slot_r[SW'(used_r)] <= code_sel;
          used_r <= used_r + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        out_slot_r[k] <= (k < REPORT_KEYS) ? slot_r[SW'(k)] : 8'h00;
      end
      out_mods_r <= mods_r;
      out_used_r <= used_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_slot0     = out_slot_r[0];
  assign out_key_slot1     = out_slot_r[1];
  assign out_key_slot2     = out_slot_r[2];
  assign out_key_slot3     = out_slot_r[3];
  assign out_key_slot4     = out_slot_r[4];
  assign out_key_slot5     = out_slot_r[5];
  assign out_modifier_mask = out_mods_r;
  assign out_keys_used     = 3'(out_used_r);

  // checks
  `KMH_ASSERT_NEXT(a_report_starts_scan, report_start, state_r == S_FN_PASS, "report did not start scan")
  `KMH_ASSERT_NOW(a_used_bound, 1'b1, used_r <= USED_MAX, "slot count beyond report size")
  `KMH_ASSERT_NOW(a_flush_has_read, state_r == S_FLUSH, v_r && key_pass_r, "flush without last key read")
  `KMH_ASSERT_NOW(a_idle_no_read, state_r == S_IDLE, !v_r, "memory read in flight while idle")
  `KMH_ASSERT_NEXT(a_emit_loads, emit_go, out_valid && (out_keys_used == 3'($past(used_r))), "report beat not loaded")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the keyboard matrix to hid boot report block
module tb;
  import kmh_pkg::*;

  localparam int ROWS        = ROWS_DEF;
  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int REPORT_KEYS = REPORT_KEYS_DEF;
  localparam int MAP_DEPTH   = ROWS * COLUMNS;

  localparam int BEAT_TARGET  = 1950;
  localparam int TAIL_BEATS   = 150;
  localparam int DRAIN_CYCLES = 2 * MAP_DEPTH + 40;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // opcodes the block ignores
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [7:0] NO_KEY = 8'h00;
  // row 0 normal layout, column 0 in the low byte: key, modifiers, empty,
  // unreportable, top and bottom key codes, code just past the modifiers
  localparam logic [63:0] ROW0_NORMAL = 64'hE8_01_EF_F0_00_E7_E0_04;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] row;
    logic [2:0] column;
    logic [7:0] code;
    logic [7:0] sense;
  } scan_beat_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0][7:0] slot;
    logic [7:0]                 mods;
    logic [2:0]                 used;
  } boot_report_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_opcode = '0;
  logic [3:0] in_row = '0;
  logic [2:0] in_column = '0;
  logic [7:0] in_map_code = '0;
  logic [7:0] in_sense_bits = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_key_slot0, out_key_slot1, out_key_slot2;
  logic [7:0] out_key_slot3, out_key_slot4, out_key_slot5;
  logic [7:0] out_modifier_mask;
  logic [2:0] out_keys_used;

  // shadow copy of the keymaps and debounce samples
  logic [7:0] normal_keys [MAP_DEPTH];
  logic [7:0] fn_keys [MAP_DEPTH];
  logic [7:0] first_rows [ROWS];
  logic [7:0] second_rows [ROWS];

  scan_beat_t   pending_beats [$];
  boot_report_t report_queue [$];
  scan_beat_t   beat_on_bus;

  int send_gap = 0;
  int recv_stall = 0;
  int cycle_count = 0;
  int error_count = 0;
  int beats_accepted = 0;
  int reports_checked = 0;
  int fn_reports = 0;
  int full_reports = 0;

  key_matrix_to_hid_report DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_row            (in_row),
    .in_column         (in_column),
    .in_map_code       (in_map_code),
    .in_sense_bits     (in_sense_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_key_slot0     (out_key_slot0),
    .out_key_slot1     (out_key_slot1),
    .out_key_slot2     (out_key_slot2),
    .out_key_slot3     (out_key_slot3),
    .out_key_slot4     (out_key_slot4),
    .out_key_slot5     (out_key_slot5),
    .out_modifier_mask (out_modifier_mask),
    .out_keys_used     (out_keys_used)
  );

  always #5 clk = ~clk;

  // expected boot report from the shadow keymaps and samples
  function automatic boot_report_t build_report();
    boot_report_t rpt;
    logic         fn_layer;
    logic [7:0]   down;
    logic [7:0]   code;
    int           slot_n;
    rpt = '0;
    fn_layer = 1'b0;
    slot_n = 0;
    // function key pass over the normal layer
    for (int r = 0; r < ROWS; r++) begin
      down = first_rows[r] & second_rows[r];
      for (int c = 0; c < COLUMNS; c++)
        if (down[c] && normal_keys[r * COLUMNS + c] == FN_CODE) fn_layer = 1'b1;
    end
    // key pass in scan order over the selected layer
    for (int r = 0; r < ROWS; r++) begin
      down = first_rows[r] & second_rows[r];
      for (int c = 0; c < COLUMNS; c++) begin
        if (down[c]) begin
          code = fn_layer ? fn_keys[r * COLUMNS + c] : normal_keys[r * COLUMNS + c];
          if (code == NO_KEY || code >= KEY_LIMIT) begin
            // not reported
          end else if (code[7:3] == MOD_PREFIX) begin
            rpt.mods[code[2:0]] = 1'b1;
          end else if (slot_n < REPORT_KEYS) begin
            rpt.slot[slot_n] = code;
            slot_n++;
          end
        end
      end
    end
    rpt.used = slot_n[2:0];
    if (fn_layer) fn_reports++;
    if (slot_n == REPORT_KEYS) full_reports++;
    return rpt;
  endfunction

  // update the shadow state with one accepted beat
  function automatic void apply_beat(scan_beat_t b);
    int idx;
    idx = b.row * COLUMNS + b.column;
    case (b.op)
      OP_LOAD_NORMAL:   normal_keys[idx] = b.code;
      OP_LOAD_FN:       fn_keys[idx] = b.code;
      OP_SAMPLE_FIRST:  first_rows[b.row] = b.sense;
      OP_SAMPLE_SECOND: second_rows[b.row] = b.sense;
      OP_REPORT:        report_queue.push_back(build_report());
      default: ;
    endcase
  endfunction

  // compare one result beat against the oldest expected report
  function automatic void check_report();
    boot_report_t want;
    boot_report_t got;
    got.slot = {out_key_slot5, out_key_slot4, out_key_slot3,
                out_key_slot2, out_key_slot1, out_key_slot0};
    got.mods = out_modifier_mask;
    got.used = out_keys_used;
    if (report_queue.size() == 0) begin
      $error("report beat with no request outstanding");
      error_count++;
      return;
    end
    want = report_queue.pop_front();
    reports_checked++;
    for (int k = 0; k < SLOT_COUNT; k++)
      if (got.slot[k] !== want.slot[k]) begin
        $error("key_slot%0d: expected %0h, got %0h", k, want.slot[k], got.slot[k]);
        error_count++;
      end
    if (got.mods !== want.mods) begin
      $error("modifier_mask: expected %0h, got %0h", want.mods, got.mods);
      error_count++;
    end
    if (got.used !== want.used) begin
      $error("keys_used: expected %0d, got %0d", want.used, got.used);
      error_count++;
    end
  endfunction

  // no idling near the end and in every fourth window of cycles
  function automatic bit idling_allowed();
    return pending_beats.size() > TAIL_BEATS && (cycle_count / 4096) % 4 != 3;
  endfunction

  // keycode mix: empty, modifiers, function key, unreportable, plain keys
  function automatic logic [7:0] rand_code();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return NO_KEY;
    else if (pick < 22) return {MOD_PREFIX, 3'($urandom)};
    else if (pick < 27) return FN_CODE;
    else if (pick < 33) return 8'($urandom_range(KEY_LIMIT, 8'hFE));
    else return 8'($urandom_range(1, KEY_LIMIT - 1));
  endfunction

  // beat builders; fields the operation does not use get random values
  function automatic void load_key(logic [2:0] op, int r, int c, logic [7:0] code);
    pending_beats.push_back({op, 4'(r), 3'(c), code, 8'($urandom)});
  endfunction

  function automatic void sample_row(logic [2:0] op, int r, logic [7:0] bits);
    pending_beats.push_back({op, 4'(r), 3'($urandom), 8'($urandom), bits});
  endfunction

  function automatic void request_report();
    pending_beats.push_back({OP_REPORT, 4'($urandom), 3'($urandom),
                             8'($urandom), 8'($urandom)});
  endfunction

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // retire the accepted beat into the shadow state
      if (in_valid && in_ready) begin
        apply_beat(beat_on_bus);
        beats_accepted++;
      end
      // present the next beat once the bus is free
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          beat_on_bus = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_opcode <= beat_on_bus.op;
          in_row <= beat_on_bus.row;
          in_column <= beat_on_bus.column;
          in_map_code <= beat_on_bus.code;
          in_sense_bits <= beat_on_bus.sense;
          if (idling_allowed() && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor with random receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_report();
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 5) == 0)
          recv_stall = $urandom_range(1, 12);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int         pick;
    int         n;
    int         r;
    logic [7:0] mask;
    foreach (first_rows[i]) first_rows[i] = '0;
    foreach (second_rows[i]) second_rows[i] = '0;

    // report with nothing pressed, then the ignored opcodes
    request_report();
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      pending_beats.push_back({3'(op), 4'($urandom), 3'($urandom),
                               8'($urandom), 8'($urandom)});

    // load every entry of both layers, rows 0 and 15 of the normal layer with a fixed layout
    for (int i = 0; i < MAP_DEPTH; i++) begin
      r = i / COLUMNS;
      if (r == 0)
        load_key(OP_LOAD_NORMAL, r, i % COLUMNS, ROW0_NORMAL[(i % COLUMNS) * 8 +: 8]);
      else if (r == ROWS - 1)
        load_key(OP_LOAD_NORMAL, r, i % COLUMNS,
                 (i % COLUMNS == COLUMNS - 1) ? FN_CODE : 8'(8'h10 + i % COLUMNS));
      else
        load_key(OP_LOAD_NORMAL, r, i % COLUMNS, rand_code());
      load_key(OP_LOAD_FN, r, i % COLUMNS, rand_code());
    end

    // first sample alone presses nothing
    sample_row(OP_SAMPLE_FIRST, 0, 8'hFF);
    request_report();
    // whole row 0 down: modifiers, skipped codes and plain keys
    sample_row(OP_SAMPLE_SECOND, 0, 8'hFF);
    request_report();
    // more keys than slots, function key held up by debounce
    sample_row(OP_SAMPLE_FIRST, ROWS - 1, 8'h7F);
    sample_row(OP_SAMPLE_SECOND, ROWS - 1, 8'hFF);
    request_report();
    // function key down switches the whole report to the fn layer
    sample_row(OP_SAMPLE_FIRST, ROWS - 1, 8'hFF);
    request_report();
    // release everything
    sample_row(OP_SAMPLE_FIRST, ROWS - 1, 8'h00);
    sample_row(OP_SAMPLE_FIRST, 0, 8'h00);
    request_report();

    // random scan sequences
    while (pending_beats.size() < BEAT_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // a few rows with sparse presses and debounce noise, then a report
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(0, ROWS - 1);
          mask = 8'($urandom & $urandom);
          sample_row(OP_SAMPLE_FIRST, r, mask | 8'($urandom & $urandom & $urandom));
          sample_row(OP_SAMPLE_SECOND, r, mask | 8'($urandom & $urandom & $urandom));
        end
        n = $urandom_range(0, 2);
        for (int k = 0; k < n; k++)
          sample_row($urandom_range(0, 1) ? OP_SAMPLE_FIRST : OP_SAMPLE_SECOND,
                     $urandom_range(0, ROWS - 1), 8'h00);
        if ($urandom_range(0, 2) == 0)
          load_key($urandom_range(0, 1) ? OP_LOAD_NORMAL : OP_LOAD_FN,
                   $urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1),
                   rand_code());
        request_report();
      end else if (pick < 70) begin
        // dense rows overflow the key slots
        n = $urandom_range(3, 6);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(0, ROWS - 1);
          sample_row(OP_SAMPLE_FIRST, r, 8'($urandom));
          sample_row(OP_SAMPLE_SECOND, r, 8'($urandom));
        end
        request_report();
      end else if (pick < 85) begin
        // keymap remapping burst
        n = $urandom_range(2, 8);
        for (int k = 0; k < n; k++)
          load_key($urandom_range(0, 1) ? OP_LOAD_NORMAL : OP_LOAD_FN,
                   $urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1),
                   rand_code());
      end else if (pick < 92) begin
        // release all rows, first sample left with random contacts
        for (int k = 0; k < ROWS; k++) begin
          sample_row(OP_SAMPLE_SECOND, k, 8'h00);
          if ($urandom_range(0, 3) == 0) sample_row(OP_SAMPLE_FIRST, k, 8'($urandom));
        end
        request_report();
      end else begin
        // random noise beats, ignored opcodes included
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) == 0)
            pending_beats.push_back({3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                                     4'($urandom), 3'($urandom), 8'($urandom),
                                     8'($urandom)});
          else
            load_key(3'($urandom_range(OP_LOAD_NORMAL, OP_LOAD_FN)),
                     $urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1),
                     8'($urandom));
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_beats.size() == 0 && !in_valid);
    wait (report_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d command beats driven, %0d boot reports compared",
             beats_accepted, reports_checked);
    $display("%0d reports took the function layer, %0d filled every key slot",
             fn_reports, full_reports);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
